// ----- src/psfa_pkg.sv -----
// Shared types, codes and constants of the page segment fit allocator.
// No dependencies; every other file of the block uses it by scoped names.
package psfa_pkg;

	// Fixed field widths
	localparam int PAGE_W   = 24;
	localparam int BYTE_W   = 25;
	localparam int PB_W     = 17;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 25;

	// Parameter defaults
	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int OWNER_BITS_DEF   = 8;

	// Register reset values and the page cap
	localparam logic           FIT_POLICY_RST   = 1'b1;
	localparam logic [BYTE_W-1:0] MEMORY_BYTES_RST = 25'd65536;
	localparam logic [PB_W-1:0]   PAGE_BYTES_RST   = 17'd16;
	localparam logic [BYTE_W-1:0] PAGE_CAP         = 25'h1000000;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC      = 2'd0,
		OP_PLACE      = 2'd1,
		OP_FREE_OWNER = 2'd2,
		OP_FREE_HEAD  = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NO_FIT    = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_BAD_PLACE = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIT_POLICY   = 2'd0,
		CFG_MEMORY_BYTES = 2'd1,
		CFG_PAGE_BYTES   = 2'd2
	} cfg_index_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV_TOTAL, S_DIV_SIZE, S_CHECK, S_SCAN_PRIME, S_SCAN, S_DECIDE,
		S_INS_PRIME, S_INS, S_WRITE_NEW, S_REM_PRIME, S_REM, S_DROP, S_HEAD,
		S_RESULT
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_LOAD, CMD_TAKE_TOTAL, CMD_TAKE_SIZE, CMD_CHECK,
		CMD_SCAN_PRIME, CMD_SCAN, CMD_INS_PRIME, CMD_INS, CMD_WRITE_NEW,
		CMD_REM_PRIME, CMD_REM, CMD_DROP, CMD_HEAD_READ, CMD_OUT_LOAD
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic pre_decided;
		logic scan_done;
		logic ok;
		logic is_insert;
		logic ins_shift;
		logic rem_shift;
		logic ins_end;
		logic rem_end;
	} dp_status_t;

endpackage

// ----- src/psfa_div.sv -----
// Iterative restoring divider giving a rounded-up quotient, one bit a cycle.
// Depends on psfa_pkg for the byte and page-size widths.
module psfa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [psfa_pkg::BYTE_W-1:0]   dividend,
	input  logic [psfa_pkg::PB_W-1:0]     divisor,
	output logic                          done,
	output logic [psfa_pkg::BYTE_W:0]     quotient
);
	localparam int DW   = psfa_pkg::BYTE_W;
	localparam int RW   = psfa_pkg::PB_W;
	localparam int CNTW = $clog2(DW);

	logic [RW-1:0]   rem_q;
	logic [DW-1:0]   quo_q;
	logic [RW-1:0]   div_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RW:0]     shifted;
	logic [RW:0]     diff;
	logic            ge;

	// One trial subtraction per cycle
	assign shifted = {rem_q, quo_q[DW-1]};
	assign ge      = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	// Control: run DW steps, then pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNTW'(DW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[RW-1:0] : shifted[RW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = {1'b0, quo_q} + (DW+1)'(rem_q != '0);

endmodule

// ----- src/psfa_dp.sv -----
// Datapath: configuration registers, segment table memory, scan and shift logic.
// Depends on psfa_pkg and psfa_div.
module psfa_dp #(
	parameter int MAX_SEGMENTS = psfa_pkg::MAX_SEGMENTS_DEF,
	parameter int OWNER_BITS   = psfa_pkg::OWNER_BITS_DEF,
	parameter int CW           = $clog2(MAX_SEGMENTS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  psfa_pkg::dp_cmd_t                 cmd,
	output psfa_pkg::dp_status_t              st,
	input  logic                              cfg_we,
	input  logic [psfa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [psfa_pkg::CFG_W-1:0]        cfg_data,
	input  logic [psfa_pkg::OP_W-1:0]         in_opcode,
	input  logic [OWNER_BITS-1:0]             in_owner,
	input  logic [psfa_pkg::BYTE_W-1:0]       in_size,
	input  logic [psfa_pkg::PAGE_W-1:0]       in_start,
	output logic [psfa_pkg::PAGE_W-1:0]       out_placed,
	output logic [psfa_pkg::STATUS_W-1:0]     out_status,
	output logic [CW-1:0]                     out_count,
	output logic                              out_head_valid,
	output logic [OWNER_BITS-1:0]             out_head_owner
);
	localparam int PW    = psfa_pkg::PAGE_W;
	localparam int BW    = psfa_pkg::BYTE_W;
	localparam int AW    = $clog2(MAX_SEGMENTS);
	localparam int MEM_W = 2 * PW + OWNER_BITS;
	localparam int GW    = BW + 2;

	// Configuration
	logic                          fit_policy_q;
	logic [BW-1:0]                 memory_bytes_q;
	logic [psfa_pkg::PB_W-1:0]     page_bytes_q;

	// Item under work
	psfa_pkg::opcode_t             op_q;
	logic [OWNER_BITS-1:0]         owner_q;
	logic [BW-1:0]                 size_q;
	logic [PW-1:0]                 start_q;
	logic [BW-1:0]                 total_q;
	logic [BW-1:0]                 sz_q;

	// Table and scan state
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 e_q;
	logic [CW-1:0]                 j_q;
	logic [CW-1:0]                 k_q;
	logic [PW-1:0]                 prev_last_q;
	logic                          found_q;
	logic signed [GW-1:0]          pick_gap_q;
	logic [CW-1:0]                 pick_k_q;
	logic [BW-1:0]                 pick_l_q;
	logic                          ok_q;
	psfa_pkg::status_t             status_q;
	logic [PW-1:0]                 placed_q;

	// Memory
	logic [MEM_W-1:0]              mem [MAX_SEGMENTS];
	logic [MEM_W-1:0]              rd_q;
	logic                          rd_en;
	logic [AW-1:0]                 rd_addr;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [MEM_W-1:0]              wr_data;

	logic [PW-1:0]                 rd_first;
	logic [PW-1:0]                 rd_last;
	logic [OWNER_BITS-1:0]         rd_owner;

	// Divider
	logic                          div_start;
	logic [BW-1:0]                 div_dividend;
	logic [psfa_pkg::PB_W-1:0]     div_divisor;
	logic                          div_done;
	logic [BW:0]                   div_quot;

	// Scan evaluation
	logic                          is_end;
	logic [BW-1:0]                 gap_l;
	logic [BW-1:0]                 gap_r;
	logic signed [GW-1:0]          gap;
	logic                          fits;
	logic                          better;
	logic                          take;
	logic                          found_n;
	logic [CW-1:0]                 pick_k_n;
	logic [BW-1:0]                 pick_l_n;
	logic [BW:0]                   last_new;
	logic                          place_stop;
	logic                          place_bad;
	logic                          owner_hit;
	logic                          scan_done;

	// Pre-check
	logic                          pre_decided;
	logic                          pre_ok;
	psfa_pkg::status_t             pre_status;
	logic                          is_insert;
	logic [BW-1:0]                 new_last;
	logic [CW:0]                   k_plus1;
	logic [CW:0]                   j_plus2;
	logic [CW-1:0]                 e_next;
	logic [CW-1:0]                 j_next;
	logic [CW-1:0]                 j_prev;
	logic [CW-1:0]                 k_next;
	logic [CW-1:0]                 count_dec;

	assign rd_first = rd_q[PW-1:0];
	assign rd_last  = rd_q[2*PW-1:PW];
	assign rd_owner = rd_q[MEM_W-1:2*PW];

	// Configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q   <= psfa_pkg::FIT_POLICY_RST;
			memory_bytes_q <= psfa_pkg::MEMORY_BYTES_RST;
			page_bytes_q   <= psfa_pkg::PAGE_BYTES_RST;
		end else if (cfg_we) begin
			unique case (psfa_pkg::cfg_index_t'(cfg_index))
				psfa_pkg::CFG_FIT_POLICY:   fit_policy_q   <= cfg_data[0];
				psfa_pkg::CFG_MEMORY_BYTES: memory_bytes_q <= cfg_data[BW-1:0];
				psfa_pkg::CFG_PAGE_BYTES:   page_bytes_q   <= cfg_data[psfa_pkg::PB_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared divider: total pages first, then request pages
	assign div_start    = (cmd == psfa_pkg::CMD_LOAD) || (cmd == psfa_pkg::CMD_TAKE_TOTAL);
	assign div_dividend = (cmd == psfa_pkg::CMD_LOAD) ? memory_bytes_q : size_q;
	assign div_divisor  = (page_bytes_q == '0) ? psfa_pkg::PB_W'(1) : page_bytes_q;

	psfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Gap between the previous segment and entry e (or the end of memory)
	assign is_end = (e_q == count_q);
	assign gap_l  = (e_q == '0) ? '0 : {1'b0, prev_last_q} + 1'b1;
	assign gap_r  = is_end ? total_q : {1'b0, rd_first};
	assign gap    = $signed({2'b00, gap_r}) - $signed({2'b00, gap_l});
	assign fits   = gap >= $signed({2'b00, sz_q});
	assign better = fit_policy_q ? (gap < pick_gap_q) : (gap > pick_gap_q);
	assign take   = fits && (!found_q || better);
	assign found_n  = found_q || take;
	assign pick_k_n = take ? e_q : pick_k_q;
	assign pick_l_n = take ? gap_l : pick_l_q;

	// Placement at a given page
	assign last_new   = {2'b00, start_q} + {1'b0, sz_q} - 1'b1;
	assign place_stop = is_end || (rd_first >= start_q);
	assign place_bad  = (last_new >= {1'b0, total_q}) ||
		((e_q != '0) && (prev_last_q >= start_q)) ||
		(!is_end && ({2'b00, rd_first} <= last_new));

	assign owner_hit = !is_end && (rd_owner == owner_q);

	always_comb begin
		case (op_q)
			psfa_pkg::OP_ALLOC:      scan_done = is_end;
			psfa_pkg::OP_PLACE:      scan_done = place_stop;
			psfa_pkg::OP_FREE_OWNER: scan_done = owner_hit || is_end;
			default:                 scan_done = 1'b1;
		endcase
	end

	// Outcomes settled before any scan
	assign is_insert = (op_q == psfa_pkg::OP_ALLOC) || (op_q == psfa_pkg::OP_PLACE);
	always_comb begin
		pre_decided = 1'b0;
		pre_ok      = 1'b0;
		pre_status  = psfa_pkg::ST_OK;
		if (is_insert) begin
			if (count_q >= CW'(MAX_SEGMENTS)) begin
				pre_decided = 1'b1;
				pre_status  = psfa_pkg::ST_FULL;
			end else if (sz_q == '0) begin
				pre_decided = 1'b1;
				pre_status  = (op_q == psfa_pkg::OP_ALLOC) ? psfa_pkg::ST_NO_FIT
				                                           : psfa_pkg::ST_BAD_PLACE;
			end
		end else if (op_q == psfa_pkg::OP_FREE_HEAD) begin
			pre_decided = 1'b1;
			pre_ok      = (count_q != '0);
			pre_status  = pre_ok ? psfa_pkg::ST_OK : psfa_pkg::ST_NOT_FOUND;
		end
	end

	assign new_last  = {1'b0, placed_q} + sz_q - 1'b1;
	assign k_plus1   = {1'b0, k_q} + 1'b1;
	assign j_plus2   = {1'b0, j_q} + 2'd2;
	assign e_next    = e_q + 1'b1;
	assign j_next    = j_q + 1'b1;
	assign j_prev    = j_q - 1'b1;
	assign k_next    = k_q + 1'b1;
	assign count_dec = count_q - 1'b1;

	// Memory port selection per command
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_q;
		case (cmd)
			psfa_pkg::CMD_SCAN_PRIME: begin
				rd_en = 1'b1;
			end
			psfa_pkg::CMD_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = AW'(e_next);
			end
			psfa_pkg::CMD_INS_PRIME: begin
				rd_en   = 1'b1;
				rd_addr = AW'(count_dec);
			end
			psfa_pkg::CMD_INS: begin
				rd_en   = 1'b1;
				rd_addr = AW'(j_prev);
				wr_en   = 1'b1;
				wr_addr = AW'(j_next);
			end
			psfa_pkg::CMD_WRITE_NEW: begin
				wr_en   = 1'b1;
				wr_addr = AW'(k_q);
				wr_data = {owner_q, new_last[PW-1:0], placed_q};
			end
			psfa_pkg::CMD_REM_PRIME: begin
				rd_en   = 1'b1;
				rd_addr = AW'(k_next);
			end
			psfa_pkg::CMD_REM: begin
				rd_en   = 1'b1;
				rd_addr = AW'(j_plus2);
				wr_en   = 1'b1;
				wr_addr = AW'(j_q);
			end
			psfa_pkg::CMD_HEAD_READ: begin
				rd_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (cmd == psfa_pkg::CMD_WRITE_NEW)
			count_q <= count_q + 1'b1;
		else if (cmd == psfa_pkg::CMD_DROP)
			count_q <= count_dec;
	end

	// Item capture, scan and outcome registers
	always_ff @(posedge clk) begin
		case (cmd)
			psfa_pkg::CMD_LOAD: begin
				op_q    <= psfa_pkg::opcode_t'(in_opcode);
				owner_q <= in_owner;
				size_q  <= in_size;
				start_q <= in_start;
			end
			psfa_pkg::CMD_TAKE_TOTAL: begin
				total_q <= (div_quot > {1'b0, psfa_pkg::PAGE_CAP}) ? psfa_pkg::PAGE_CAP
				                                                  : div_quot[BW-1:0];
			end
			psfa_pkg::CMD_TAKE_SIZE: begin
				sz_q <= div_quot[BW-1:0];
			end
			psfa_pkg::CMD_CHECK: begin
				ok_q     <= pre_ok;
				status_q <= pre_status;
				k_q      <= '0;
				placed_q <= '0;
			end
			psfa_pkg::CMD_SCAN_PRIME: begin
				e_q     <= '0;
				found_q <= 1'b0;
			end
			psfa_pkg::CMD_SCAN: begin
				e_q         <= e_next;
				prev_last_q <= rd_last;
				found_q     <= found_n;
				if (take)
					pick_gap_q <= gap;
				pick_k_q <= pick_k_n;
				pick_l_q <= pick_l_n;
				if (scan_done) begin
					case (op_q)
						psfa_pkg::OP_ALLOC: begin
							ok_q     <= found_n;
							status_q <= found_n ? psfa_pkg::ST_OK : psfa_pkg::ST_NO_FIT;
							k_q      <= pick_k_n;
							placed_q <= found_n ? pick_l_n[PW-1:0] : '0;
						end
						psfa_pkg::OP_PLACE: begin
							ok_q     <= !place_bad;
							status_q <= place_bad ? psfa_pkg::ST_BAD_PLACE : psfa_pkg::ST_OK;
							k_q      <= e_q;
							placed_q <= place_bad ? '0 : start_q;
						end
						default: begin
							ok_q     <= owner_hit;
							status_q <= owner_hit ? psfa_pkg::ST_OK : psfa_pkg::ST_NOT_FOUND;
							k_q      <= e_q;
							placed_q <= '0;
						end
					endcase
				end
			end
			psfa_pkg::CMD_INS_PRIME: j_q <= count_dec;
			psfa_pkg::CMD_INS:       j_q <= j_prev;
			psfa_pkg::CMD_REM_PRIME: j_q <= k_q;
			psfa_pkg::CMD_REM:       j_q <= j_next;
			default: ;
		endcase
	end

	// Result register; the head entry was read just before
	always_ff @(posedge clk) begin
		if (cmd == psfa_pkg::CMD_OUT_LOAD) begin
			out_placed     <= placed_q;
			out_status     <= status_q;
			out_count      <= count_q;
			out_head_valid <= (count_q != '0);
			out_head_owner <= (count_q != '0) ? rd_owner : '0;
		end
	end

	// Status towards the controller
	always_comb begin
		st.div_done    = div_done;
		st.pre_decided = pre_decided;
		st.scan_done   = scan_done;
		st.ok          = ok_q;
		st.is_insert   = is_insert;
		st.ins_shift   = count_q > k_q;
		st.rem_shift   = k_plus1 < {1'b0, count_q};
		st.ins_end     = (j_q == k_q);
		st.rem_end     = (j_plus2 == {1'b0, count_q});
	end

endmodule

// ----- src/psfa_ctrl.sv -----
// Controller state machine: sequences division, scan, table shift and result.
// Depends on psfa_pkg; drives psfa_dp by command and reads its status.
module psfa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output psfa_pkg::dp_cmd_t     cmd,
	input  psfa_pkg::dp_status_t  st
);
	psfa_pkg::state_t state_q;
	psfa_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_load;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= psfa_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and command
	always_comb begin
		state_d  = state_q;
		cmd      = psfa_pkg::CMD_NONE;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			psfa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd     = psfa_pkg::CMD_LOAD;
					state_d = psfa_pkg::S_DIV_TOTAL;
				end
			end
			psfa_pkg::S_DIV_TOTAL: begin
				if (st.div_done) begin
					cmd     = psfa_pkg::CMD_TAKE_TOTAL;
					state_d = psfa_pkg::S_DIV_SIZE;
				end
			end
			psfa_pkg::S_DIV_SIZE: begin
				if (st.div_done) begin
					cmd     = psfa_pkg::CMD_TAKE_SIZE;
					state_d = psfa_pkg::S_CHECK;
				end
			end
			psfa_pkg::S_CHECK: begin
				cmd     = psfa_pkg::CMD_CHECK;
				state_d = st.pre_decided ? psfa_pkg::S_DECIDE : psfa_pkg::S_SCAN_PRIME;
			end
			psfa_pkg::S_SCAN_PRIME: begin
				cmd     = psfa_pkg::CMD_SCAN_PRIME;
				state_d = psfa_pkg::S_SCAN;
			end
			psfa_pkg::S_SCAN: begin
				cmd = psfa_pkg::CMD_SCAN;
				if (st.scan_done)
					state_d = psfa_pkg::S_DECIDE;
			end
			psfa_pkg::S_DECIDE: begin
				if (!st.ok)
					state_d = psfa_pkg::S_HEAD;
				else if (st.is_insert)
					state_d = st.ins_shift ? psfa_pkg::S_INS_PRIME : psfa_pkg::S_WRITE_NEW;
				else
					state_d = st.rem_shift ? psfa_pkg::S_REM_PRIME : psfa_pkg::S_DROP;
			end
			psfa_pkg::S_INS_PRIME: begin
				cmd     = psfa_pkg::CMD_INS_PRIME;
				state_d = psfa_pkg::S_INS;
			end
			psfa_pkg::S_INS: begin
				cmd = psfa_pkg::CMD_INS;
				if (st.ins_end)
					state_d = psfa_pkg::S_WRITE_NEW;
			end
			psfa_pkg::S_WRITE_NEW: begin
				cmd     = psfa_pkg::CMD_WRITE_NEW;
				state_d = psfa_pkg::S_HEAD;
			end
			psfa_pkg::S_REM_PRIME: begin
				cmd     = psfa_pkg::CMD_REM_PRIME;
				state_d = psfa_pkg::S_REM;
			end
			psfa_pkg::S_REM: begin
				cmd = psfa_pkg::CMD_REM;
				if (st.rem_end)
					state_d = psfa_pkg::S_DROP;
			end
			psfa_pkg::S_DROP: begin
				cmd     = psfa_pkg::CMD_DROP;
				state_d = psfa_pkg::S_HEAD;
			end
			psfa_pkg::S_HEAD: begin
				cmd     = psfa_pkg::CMD_HEAD_READ;
				state_d = psfa_pkg::S_RESULT;
			end
			psfa_pkg::S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd      = psfa_pkg::CMD_OUT_LOAD;
					out_load = 1'b1;
					state_d  = psfa_pkg::S_IDLE;
				end
			end
			default: state_d = psfa_pkg::S_IDLE;
		endcase
	end

	// Output word valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/page_segment_fit_allocator.sv -----
// Top level of the page segment fit allocator: stream ports, config port.
// Depends on psfa_pkg, psfa_ctrl and psfa_dp.
//
//  channel  | direction | handshake               | contents
//  s_axis   | in        | s_axis_tvalid/tready    | request word, opcode in tuser
//  m_axis   | out       | m_axis_tvalid/tready    | result word
//  cfg      | in        | cfg_we, no wait         | fit_policy, memory_bytes, page_bytes
//
// Each word takes two passes of the shared divider (25 steps each), a scan over
// the table entries, a move of the entries through the table memory where the
// table must shift, and the sequencing states.
// Reset clears the segment count and loads the register defaults; no clearing pass.
// A new word is taken while the previous result still waits on m_axis.
module page_segment_fit_allocator #(
	parameter int MAX_SEGMENTS = psfa_pkg::MAX_SEGMENTS_DEF,
	parameter int OWNER_BITS   = psfa_pkg::OWNER_BITS_DEF,
	parameter int CW           = $clog2(MAX_SEGMENTS + 1),
	parameter int S_BITS       = OWNER_BITS + psfa_pkg::BYTE_W + psfa_pkg::PAGE_W,
	parameter int S_TDATA_W    = ((S_BITS + 7) / 8) * 8,
	parameter int M_BITS       = psfa_pkg::PAGE_W + psfa_pkg::STATUS_W + CW + 1 + OWNER_BITS,
	parameter int M_TDATA_W    = ((M_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// owner_id, size_bytes, start_page
	input  logic [S_TDATA_W-1:0]            s_axis_tdata,
	// opcode
	input  logic [psfa_pkg::OP_W-1:0]       s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// placed_page, status, entry_count, head_valid, head_owner
	output logic [M_TDATA_W-1:0]            m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [psfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psfa_pkg::CFG_W-1:0]      cfg_data
);
	localparam int PW = psfa_pkg::PAGE_W;
	localparam int BW = psfa_pkg::BYTE_W;

	psfa_pkg::dp_cmd_t             cmd;
	psfa_pkg::dp_status_t          st;
	logic [PW-1:0]                 out_placed;
	logic [psfa_pkg::STATUS_W-1:0] out_status;
	logic [CW-1:0]                 out_count;
	logic                          out_head_valid;
	logic [OWNER_BITS-1:0]         out_head_owner;

	psfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.st        (st)
	);

	psfa_dp #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.OWNER_BITS   (OWNER_BITS),
		.CW           (CW)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_opcode      (s_axis_tuser),
		.in_owner       (s_axis_tdata[OWNER_BITS-1:0]),
		.in_size        (s_axis_tdata[OWNER_BITS+BW-1:OWNER_BITS]),
		.in_start       (s_axis_tdata[S_BITS-1:OWNER_BITS+BW]),
		.out_placed     (out_placed),
		.out_status     (out_status),
		.out_count      (out_count),
		.out_head_valid (out_head_valid),
		.out_head_owner (out_head_owner)
	);

	// Pack the result word, zero-filled to whole bytes
	assign m_axis_tdata = M_TDATA_W'({out_head_owner, out_head_valid, out_count,
		out_status, out_placed});

endmodule

// ----- src/psfa_checker.sv -----
// Port-level checks of the page segment fit allocator, bound to the top level.
// Depends on psfa_pkg and page_segment_fit_allocator.
module psfa_checker #(
	parameter int MAX_SEGMENTS = psfa_pkg::MAX_SEGMENTS_DEF,
	parameter int OWNER_BITS   = psfa_pkg::OWNER_BITS_DEF,
	parameter int M_TDATA_W    = 48
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);
	localparam int CW    = $clog2(MAX_SEGMENTS + 1);
	localparam int ST_LO = psfa_pkg::PAGE_W;
	localparam int CN_LO = ST_LO + psfa_pkg::STATUS_W;
	localparam int HV    = CN_LO + CW;
	localparam int HO_LO = HV + 1;

	logic [psfa_pkg::PAGE_W-1:0]   placed;
	logic [psfa_pkg::STATUS_W-1:0] status;
	logic [CW-1:0]                 count;
	logic                          head_valid;
	logic [OWNER_BITS-1:0]         head_owner;

	assign placed     = m_axis_tdata[psfa_pkg::PAGE_W-1:0];
	assign status     = m_axis_tdata[CN_LO-1:ST_LO];
	assign count      = m_axis_tdata[HV-1:CN_LO];
	assign head_valid = m_axis_tdata[HV];
	assign head_owner = m_axis_tdata[HO_LO+OWNER_BITS-1:HO_LO];

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// One word at a time: busy after an accepted word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while a word is at work");

	// Head flag agrees with the count
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (head_valid == (count != '0)) &&
		(head_valid || head_owner == '0))
		else $error("head fields disagree with entry count");

	// Only a successful placement reports a nonzero page
	a_placed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && placed != '0 |-> status == psfa_pkg::ST_OK)
		else $error("page reported with failing status");

endmodule

bind page_segment_fit_allocator psfa_checker #(
	.MAX_SEGMENTS (MAX_SEGMENTS),
	.OWNER_BITS   (OWNER_BITS),
	.M_TDATA_W    (M_TDATA_W)
) u_psfa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
